// ----- rtl/core/wipf_pkg.sv -----
// shared constants for the windowed integral pid fan controller
`default_nettype none
package wipf_pkg;

    localparam int WINDOW_DEPTH_DEF = 256;

    localparam int FLOW_W  = 16;
    localparam int GAIN_W  = 24;
    localparam int ERR_W   = FLOW_W + 1;
    localparam int DUTY_W  = 9;
    localparam int CFG_AW  = 8;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;

    localparam int FULL_SCALE = 256;
    localparam int DUTY_SHIFT = 16;

    localparam logic [CFG_AW-1:0] REG_TARGET_FLOW = 8'd0;
    localparam logic [CFG_AW-1:0] REG_PROP_GAIN   = 8'd1;
    localparam logic [CFG_AW-1:0] REG_INTEG_GAIN  = 8'd2;
    localparam logic [CFG_AW-1:0] REG_DERIV_GAIN  = 8'd3;

    localparam logic [FLOW_W-1:0] TARGET_FLOW_RST = 16'd0;
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 24'd7680;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 24'd435200;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 24'd0;

endpackage
`default_nettype wire

// ----- rtl/core/windowed_integral_pid_fan.sv -----
// each accepted word is registered by stages 0, 1, 2 and 3 in turn before it is output
// throughput: one word per cycle unless the output stalls; the error ring is a read-first
//   memory read and written at the same slot in the accept cycle, so slots never collide
// the window sum and last error update in stage one, once per word, in order
// reset clears control state; the ring reads as zero until the write pointer
//   has wrapped once, so no clearing pass is needed after reset
`default_nettype none
module windowed_integral_pid_fan #(
    parameter int WINDOW_DEPTH = wipf_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // measured_flow [15:0]
    input  wire logic [wipf_pkg::TDATA_IN_W-1:0]     i_s_tdata,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // fan_duty [8:0], zeros [15:9]
    output logic [wipf_pkg::TDATA_OUT_W-1:0]         o_m_tdata,
    // clipped [0]
    output logic                                     o_m_tuser,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [wipf_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  wire logic [wipf_pkg::GAIN_W-1:0]         i_cfg_data
);

    localparam int ERR_W  = wipf_pkg::ERR_W;
    localparam int GAIN_W = wipf_pkg::GAIN_W;
    localparam int FLOW_W = wipf_pkg::FLOW_W;
    localparam int DUTY_W = wipf_pkg::DUTY_W;
    localparam int PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = ERR_W + PTR_W;
    localparam int PI_W   = SUM_W + GAIN_W + 1;
    localparam int PP_W   = ERR_W + GAIN_W + 1;
    localparam int PD_W   = ERR_W + GAIN_W + 2;
    localparam int ACC_W  = SUM_W + GAIN_W + 3;
    localparam logic signed [ACC_W-1:0] FULL_ACC =
        ACC_W'(wipf_pkg::FULL_SCALE) <<< wipf_pkg::DUTY_SHIFT;

    // configuration
    logic [FLOW_W-1:0] r_target;
    logic [GAIN_W-1:0] r_prop, r_integ, r_deriv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= wipf_pkg::TARGET_FLOW_RST;
            r_prop   <= wipf_pkg::PROP_GAIN_RST;
            r_integ  <= wipf_pkg::INTEG_GAIN_RST;
            r_deriv  <= wipf_pkg::DERIV_GAIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                wipf_pkg::REG_TARGET_FLOW: r_target <= i_cfg_data[FLOW_W-1:0];
                wipf_pkg::REG_PROP_GAIN:   r_prop   <= i_cfg_data;
                wipf_pkg::REG_INTEG_GAIN:  r_integ  <= i_cfg_data;
                wipf_pkg::REG_DERIV_GAIN:  r_deriv  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_v1, r_v2, r_v3, r_ov;
    logic w_en_o, w_mv3, w_mv2, w_mv1, w_accept;

    assign w_en_o   = !r_ov || i_m_tready;
    assign w_mv3    = !r_v3 || w_en_o;
    assign w_mv2    = !r_v2 || w_mv3;
    assign w_mv1    = !r_v1 || w_mv2;
    assign o_s_tready = w_mv1;
    assign w_accept = i_s_tvalid && w_mv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_mv1)  r_v1 <= i_s_tvalid;
            if (w_mv2)  r_v2 <= r_v1;
            if (w_mv3)  r_v3 <= r_v2;
            if (w_en_o) r_ov <= r_v3;
        end
    end

    // stage 0: error, ring access
    logic [PTR_W-1:0]        r_ptr;
    logic                    r_wrapped;
    logic signed [ERR_W-1:0] w_err;
    logic [ERR_W-1:0]        r_ring [WINDOW_DEPTH];
    logic [ERR_W-1:0]        r_rd1;
    logic signed [ERR_W-1:0] r_err1;
    logic                    r_old_ok1;

    assign w_err = $signed({1'b0, r_target}) - $signed({1'b0, i_s_tdata[FLOW_W-1:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_wrapped <= 1'b0;
        end else if (w_accept) begin
            if (r_ptr == PTR_W'(WINDOW_DEPTH - 1)) begin
                r_ptr     <= '0;
                r_wrapped <= 1'b1;
            end else begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd1         <= r_ring[r_ptr];
            r_ring[r_ptr] <= w_err;
            r_err1        <= w_err;
            r_old_ok1     <= r_wrapped;
        end
    end

    // stage 1: window sum and difference
    logic signed [SUM_W-1:0] r_sum, r_sum2, n_sum;
    logic signed [ERR_W-1:0] r_last, w_old;
    logic signed [ERR_W:0]   w_diff, r_diff2;
    logic signed [ERR_W-1:0] r_err2;
    logic                    w_adv1;

    assign w_adv1 = r_v1 && w_mv2;
    assign w_old  = r_old_ok1 ? $signed(r_rd1) : '0;
    assign n_sum  = r_sum + {{(SUM_W-ERR_W){r_err1[ERR_W-1]}}, r_err1}
                          - {{(SUM_W-ERR_W){w_old[ERR_W-1]}}, w_old};
    assign w_diff = {r_err1[ERR_W-1], r_err1} - {r_last[ERR_W-1], r_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_last <= '0;
        end else if (w_adv1) begin
            r_sum  <= n_sum;
            r_last <= r_err1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_sum2  <= n_sum;
            r_diff2 <= w_diff;
            r_err2  <= r_err1;
        end
    end

    // stage 2: products
    logic signed [PP_W-1:0] w_pp, r_pp;
    logic signed [PI_W-1:0] w_pi, r_pi;
    logic signed [PD_W-1:0] w_pd, r_pd;

    assign w_pp = $signed({1'b0, r_prop})  * r_err2;
    assign w_pi = $signed({1'b0, r_integ}) * r_sum2;
    assign w_pd = $signed({1'b0, r_deriv}) * r_diff2;

    always_ff @(posedge i_clk) begin
        if (r_v2 && w_mv3) begin
            r_pp <= w_pp;
            r_pi <= w_pi;
            r_pd <= w_pd;
        end
    end

    // stage 3: sum and saturate
    logic signed [ACC_W-1:0] w_acc;
    logic [DUTY_W-1:0]       w_duty, r_duty;
    logic                    w_clip, r_clip;

    assign w_acc = {{(ACC_W-PP_W){r_pp[PP_W-1]}}, r_pp}
                 + {{(ACC_W-PI_W){r_pi[PI_W-1]}}, r_pi}
                 + {{(ACC_W-PD_W){r_pd[PD_W-1]}}, r_pd};

    always_comb begin
        if (w_acc[ACC_W-1]) begin
            w_duty = '0;
            w_clip = 1'b1;
        end else if (w_acc > FULL_ACC) begin
            w_duty = DUTY_W'(wipf_pkg::FULL_SCALE);
            w_clip = 1'b1;
        end else begin
            w_duty = w_acc[wipf_pkg::DUTY_SHIFT +: DUTY_W];
            w_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && w_en_o) begin
            r_duty <= w_duty;
            r_clip <= w_clip;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {{(wipf_pkg::TDATA_OUT_W-DUTY_W){1'b0}}, r_duty};
    assign o_m_tuser  = r_clip;

    // checks
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_duty <= DUTY_W'(wipf_pkg::FULL_SCALE))
        else $error("duty above full scale");

    a_clip_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_clip |-> (r_duty == '0 || r_duty == DUTY_W'(wipf_pkg::FULL_SCALE)))
        else $error("clipped duty not at an end");

    a_ptr_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_ptr != $past(r_ptr))
        else $error("ring pointer did not advance");

    a_wrap_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_wrapped))
        else $error("wrap flag cleared without reset");

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_v1)
        else $error("accepted word lost at stage one");

endmodule
`default_nettype wire

// ----- test/tb_windowed_integral_pid_fan.sv -----
// self-checking testbench for the windowed integral pid fan controller
`timescale 1ns / 1ps
module tb_windowed_integral_pid_fan;

    localparam int WINDOW_DEPTH = wipf_pkg::WINDOW_DEPTH_DEF;
    localparam int FLOW_W       = wipf_pkg::FLOW_W;
    localparam int GAIN_W       = wipf_pkg::GAIN_W;
    localparam int ERR_W        = wipf_pkg::ERR_W;
    localparam int DUTY_W       = wipf_pkg::DUTY_W;
    localparam int CFG_AW       = wipf_pkg::CFG_AW;
    localparam int TDATA_IN_W   = wipf_pkg::TDATA_IN_W;
    localparam int TDATA_OUT_W  = wipf_pkg::TDATA_OUT_W;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 60;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DIR_ROWS     = 33;
    localparam logic [CFG_AW-1:0] REG_STRAY_LO = 8'd4;
    localparam logic [CFG_AW-1:0] REG_STRAY_HI = 8'hFF;

    typedef enum logic [1:0] {ROW_CFG, ROW_CHECK, ROW_TYPED} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [CFG_AW-1:0] addr;
        logic [GAIN_W-1:0] data;
        logic [FLOW_W-1:0] flow;
        logic [DUTY_W-1:0] duty;
        logic              clip;
    } t_dir_row;

    typedef struct {
        logic [DUTY_W-1:0] duty;
        logic              clip;
    } t_duty_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [TDATA_IN_W-1:0]  i_s_tdata = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [TDATA_OUT_W-1:0] o_m_tdata;
    logic                   o_m_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b1;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_AW-1:0]      i_cfg_addr = '0;
    logic [GAIN_W-1:0]      i_cfg_data = '0;

    windowed_integral_pid_fan #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    // controller state mirror
    logic signed [ERR_W-1:0] flow_err_ring [WINDOW_DEPTH];
    int unsigned             ring_slot;
    longint                  window_total;
    logic signed [ERR_W-1:0] prior_err;
    logic [FLOW_W-1:0]       set_flow;
    logic [GAIN_W-1:0]       gain_p;
    logic [GAIN_W-1:0]       gain_i;
    logic [GAIN_W-1:0]       gain_d;

    t_duty_word pending_duty [$];
    t_dir_row   dir_rows [DIR_ROWS];

    bit idle_on = 1'b1;
    int stall_left = 0;
    int fail_count = 0;
    int words_checked = 0;
    int words_clipped = 0;
    int samples_sent = 0;
    int settings_used = 0;
    int cycle_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void predict_fan_duty(input logic [FLOW_W-1:0] flow,
                                             output logic [DUTY_W-1:0] duty,
                                             output logic clip);
        longint err;
        longint acc;
        err = longint'(set_flow) - longint'(flow);
        window_total += err - longint'(flow_err_ring[ring_slot]);
        flow_err_ring[ring_slot] = err[ERR_W-1:0];
        ring_slot = (ring_slot + 1) % WINDOW_DEPTH;
        acc = longint'(gain_p) * err + longint'(gain_i) * window_total
            + longint'(gain_d) * (err - longint'(prior_err));
        prior_err = err[ERR_W-1:0];
        if (acc < 0) begin
            duty = '0;
            clip = 1'b1;
        end else if (acc > (longint'(wipf_pkg::FULL_SCALE) << wipf_pkg::DUTY_SHIFT)) begin
            duty = DUTY_W'(wipf_pkg::FULL_SCALE);
            clip = 1'b1;
        end else begin
            duty = DUTY_W'(acc >>> wipf_pkg::DUTY_SHIFT);
            clip = 1'b0;
        end
    endfunction

    task automatic send_flow(input logic [FLOW_W-1:0] flow, input bit typed,
                             input logic [DUTY_W-1:0] exp_duty, input logic exp_clip);
        logic [DUTY_W-1:0] duty;
        logic              clip;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = flow;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_fan_duty(flow, duty, clip);
        if (typed) begin
            pending_duty.push_back('{exp_duty, exp_clip});
        end else begin
            pending_duty.push_back('{duty, clip});
        end
        samples_sent++;
    endtask

    // hold off until every duty word is back and the pipeline has emptied
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_duty.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [GAIN_W-1:0] data);
        drain_pipeline();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (addr)
            wipf_pkg::REG_TARGET_FLOW: set_flow = data[FLOW_W-1:0];
            wipf_pkg::REG_PROP_GAIN:   gain_p = data;
            wipf_pkg::REG_INTEG_GAIN:  gain_i = data;
            wipf_pkg::REG_DERIV_GAIN:  gain_d = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready = 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_m_tready = 1'b0;
        end else begin
            i_m_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_duty_word             want;
        logic [TDATA_OUT_W-1:0] want_data;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_duty.size() == 0) begin
                $display("%0t: unexpected duty word tdata=%h tuser=%b",
                         $time, o_m_tdata, o_m_tuser);
                fail_count++;
            end else begin
                want = pending_duty.pop_front();
                want_data = TDATA_OUT_W'(want.duty);
                if (o_m_tdata !== want_data) begin
                    $display("%0t: fan_duty mismatch expected %h actual %h",
                             $time, want_data, o_m_tdata);
                    fail_count++;
                end
                if (o_m_tuser !== want.clip) begin
                    $display("%0t: clipped mismatch expected %b actual %b",
                             $time, want.clip, o_m_tuser);
                    fail_count++;
                end
                words_checked++;
                if (want.clip) words_clipped++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d duty words outstanding", pending_duty.size());
            $display("tb_windowed_integral_pid_fan NOT OK");
            $finish;
        end
    end

    initial begin
        int                p;
        int                k;
        int                delta;
        logic [FLOW_W-1:0] flow;

        for (k = 0; k < WINDOW_DEPTH; k++) flow_err_ring[k] = '0;
        ring_slot    = 0;
        window_total = 0;
        prior_err    = '0;
        set_flow     = wipf_pkg::TARGET_FLOW_RST;
        gain_p       = wipf_pkg::PROP_GAIN_RST;
        gain_i       = wipf_pkg::INTEG_GAIN_RST;
        gain_d       = wipf_pkg::DERIV_GAIN_RST;

        dir_rows = '{
            '{ROW_TYPED, '0, '0, 16'h0000, 9'd0, 1'b0},
            '{ROW_TYPED, '0, '0, 16'hFFFF, 9'd0, 1'b1},
            '{ROW_TYPED, '0, '0, 16'h8000, 9'd0, 1'b1},
            '{ROW_CFG, wipf_pkg::REG_INTEG_GAIN, 24'h000000, '0, '0, 1'b0},
            '{ROW_CFG, wipf_pkg::REG_PROP_GAIN, 24'h010000, '0, '0, 1'b0},
            // upper bits beyond the set point width must drop
            '{ROW_CFG, wipf_pkg::REG_TARGET_FLOW, 24'hFF0100, '0, '0, 1'b0},
            '{ROW_TYPED, '0, '0, 16'h0000, 9'd256, 1'b0},
            '{ROW_TYPED, '0, '0, 16'h0001, 9'd255, 1'b0},
            '{ROW_TYPED, '0, '0, 16'h0101, 9'd0, 1'b1},
            '{ROW_TYPED, '0, '0, 16'h00FF, 9'd1, 1'b0},
            '{ROW_CFG, REG_STRAY_LO, 24'h000000, '0, '0, 1'b0},
            '{ROW_CFG, REG_STRAY_HI, 24'hFFFFFF, '0, '0, 1'b0},
            '{ROW_TYPED, '0, '0, 16'h0000, 9'd256, 1'b0},
            '{ROW_CFG, wipf_pkg::REG_PROP_GAIN, 24'h000000, '0, '0, 1'b0},
            '{ROW_CFG, wipf_pkg::REG_DERIV_GAIN, 24'hFFFFFF, '0, '0, 1'b0},
            '{ROW_TYPED, '0, '0, 16'h0000, 9'd0, 1'b0},
            '{ROW_TYPED, '0, '0, 16'h0200, 9'd0, 1'b1},
            '{ROW_TYPED, '0, '0, 16'h0000, 9'd256, 1'b1},
            '{ROW_CFG, wipf_pkg::REG_TARGET_FLOW, 24'h00FFFF, '0, '0, 1'b0},
            '{ROW_CFG, wipf_pkg::REG_PROP_GAIN, 24'hFFFFFF, '0, '0, 1'b0},
            '{ROW_CFG, wipf_pkg::REG_INTEG_GAIN, 24'hFFFFFF, '0, '0, 1'b0},
            '{ROW_CHECK, '0, '0, 16'h0000, '0, 1'b0},
            '{ROW_CHECK, '0, '0, 16'hFFFF, '0, 1'b0},
            '{ROW_CHECK, '0, '0, 16'h1234, '0, 1'b0},
            '{ROW_CFG, wipf_pkg::REG_TARGET_FLOW, 24'h008000, '0, '0, 1'b0},
            '{ROW_CFG, wipf_pkg::REG_PROP_GAIN, 24'h000100, '0, '0, 1'b0},
            '{ROW_CFG, wipf_pkg::REG_INTEG_GAIN, 24'h000001, '0, '0, 1'b0},
            '{ROW_CFG, wipf_pkg::REG_DERIV_GAIN, 24'h000010, '0, '0, 1'b0},
            '{ROW_CHECK, '0, '0, 16'h8000, '0, 1'b0},
            '{ROW_CHECK, '0, '0, 16'h7F00, '0, 1'b0},
            '{ROW_CHECK, '0, '0, 16'h80FF, '0, 1'b0},
            '{ROW_CHECK, '0, '0, 16'h5555, '0, 1'b0},
            '{ROW_CHECK, '0, '0, 16'hAAAA, '0, 1'b0}
        };

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (k = 0; k < DIR_ROWS; k++) begin
            case (dir_rows[k].kind)
                ROW_CFG:   write_reg(dir_rows[k].addr, dir_rows[k].data);
                ROW_TYPED: send_flow(dir_rows[k].flow, 1'b1, dir_rows[k].duty,
                                     dir_rows[k].clip);
                default:   send_flow(dir_rows[k].flow, 1'b0, '0, 1'b0);
            endcase
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            idle_on = (p != NUM_PHASES - 1);
            case (p)
                0: begin
                    write_reg(wipf_pkg::REG_TARGET_FLOW, 24'($urandom));
                    write_reg(wipf_pkg::REG_PROP_GAIN, '0);
                    write_reg(wipf_pkg::REG_INTEG_GAIN, '0);
                    write_reg(wipf_pkg::REG_DERIV_GAIN, '0);
                end
                1: begin
                    write_reg(wipf_pkg::REG_TARGET_FLOW, 24'hFFFFFF);
                    write_reg(wipf_pkg::REG_PROP_GAIN, 24'hFFFFFF);
                    write_reg(wipf_pkg::REG_INTEG_GAIN, 24'hFFFFFF);
                    write_reg(wipf_pkg::REG_DERIV_GAIN, 24'hFFFFFF);
                end
                2: begin
                    write_reg(wipf_pkg::REG_TARGET_FLOW, 24'(wipf_pkg::TARGET_FLOW_RST));
                    write_reg(wipf_pkg::REG_PROP_GAIN, wipf_pkg::PROP_GAIN_RST);
                    write_reg(wipf_pkg::REG_INTEG_GAIN, wipf_pkg::INTEG_GAIN_RST);
                    write_reg(wipf_pkg::REG_DERIV_GAIN, wipf_pkg::DERIV_GAIN_RST);
                end
                default: begin
                    write_reg(wipf_pkg::REG_TARGET_FLOW, 24'($urandom));
                    write_reg(wipf_pkg::REG_PROP_GAIN, 24'($urandom_range(0, 1 << 15)));
                    write_reg(wipf_pkg::REG_INTEG_GAIN, 24'($urandom_range(0, 64)));
                    write_reg(wipf_pkg::REG_DERIV_GAIN, 24'($urandom_range(0, 1 << 14)));
                    write_reg(CFG_AW'($urandom_range(4, 255)), 24'($urandom));
                end
            endcase
            settings_used++;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(0, 9))
                    6, 7: flow = 16'($urandom);
                    8: flow = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    9: flow = set_flow;
                    default: begin
                        delta = $urandom_range(0, 600);
                        delta -= 300;
                        flow = set_flow + 16'(delta);
                    end
                endcase
                send_flow(flow, 1'b0, '0, 1'b0);
            end
        end

        drain_pipeline();
        repeat (12) @(posedge i_clk);
        $display("ran %0d flow samples across %0d gain settings plus directed cases",
                 samples_sent, settings_used);
        $display("checked %0d duty words, %0d of them clipped", words_checked, words_clipped);
        if (fail_count == 0 && pending_duty.size() == 0) begin
            $display("tb_windowed_integral_pid_fan OK");
        end else begin
            $display("tb_windowed_integral_pid_fan NOT OK");
        end
        $finish;
    end

endmodule
